// ===== design/pcg_pkg.sv =====
// ----------------------------------------------------------------------------
// pcg_pkg: shared constants and types for the ping-pong color gradient
// Widths, register codes, status codes and the queue/divider payload types.
// ----------------------------------------------------------------------------
package pcg_pkg;

	localparam int STEP_BITS     = 16;
	localparam int IDX_BITS      = STEP_BITS + 1;
	localparam int CH_BITS       = 8;
	localparam int N_CH          = 3;
	localparam int PROD_BITS     = CH_BITS + STEP_BITS;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = (STEP_BITS > CH_BITS) ? STEP_BITS : CH_BITS;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_START_RED,
		REG_START_GREEN,
		REG_START_BLUE,
		REG_END_RED,
		REG_END_GREEN,
		REG_END_BLUE,
		REG_STEP_TOTAL
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_ZERO_TOTAL,
		ST_OUT_OF_RANGE
	} status_t;

	// channel 0 red, 1 green, 2 blue
	typedef logic [N_CH-1:0][CH_BITS-1:0] rgb_t;

	typedef struct packed {
		rgb_t                 start_color;
		rgb_t                 end_color;
		logic [STEP_BITS-1:0] total;
	} cfg_t;

	// one color channel on its way through the divider
	typedef struct packed {
		logic                 down;
		logic [PROD_BITS-1:0] rem;
		logic [CH_BITS-1:0]   quot;
	} lane_t;

	typedef struct packed {
		status_t               status;
		lane_t [N_CH-1:0]      lane;
	} job_t;

endpackage

// ===== design/pcg_step_if.sv =====
// ----------------------------------------------------------------------------
// pcg_step_if: step number channel
// Valid/ready channel carrying one gradient step index per transaction.
// ----------------------------------------------------------------------------
interface pcg_step_if;
	import pcg_pkg::*;

	logic                valid;
	logic                ready;
	logic [IDX_BITS-1:0] step_index;

	modport source (output valid, output step_index, input ready);
	modport sink (input valid, input step_index, output ready);

endinterface

// ===== design/pcg_color_if.sv =====
// ----------------------------------------------------------------------------
// pcg_color_if: color result channel
// Valid/ready channel carrying one RGB color and a status code per transaction.
// ----------------------------------------------------------------------------
interface pcg_color_if;
	import pcg_pkg::*;

	logic               valid;
	logic               ready;
	logic [CH_BITS-1:0] red;
	logic [CH_BITS-1:0] green;
	logic [CH_BITS-1:0] blue;
	logic [1:0]         status;

	modport source (output valid, output red, output green, output blue, output status,
		input ready);
	modport sink (input valid, input red, input green, input blue, input status,
		output ready);

endinterface

// ===== design/pcg_cfg.sv =====
// ----------------------------------------------------------------------------
// pcg_cfg: configuration registers
// Start color, end color and step total, written through a plain write port.
// ----------------------------------------------------------------------------
module pcg_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pcg_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [pcg_pkg::CFG_DATA_BITS-1:0] cfg_data,
	output pcg_pkg::cfg_t                   cfg
);
	import pcg_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_color <= '0;
			cfg_q.end_color   <= '1;
			cfg_q.total       <= STEP_BITS'(1);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_START_RED:   cfg_q.start_color[0] <= cfg_data[CH_BITS-1:0];
				REG_START_GREEN: cfg_q.start_color[1] <= cfg_data[CH_BITS-1:0];
				REG_START_BLUE:  cfg_q.start_color[2] <= cfg_data[CH_BITS-1:0];
				REG_END_RED:     cfg_q.end_color[0]   <= cfg_data[CH_BITS-1:0];
				REG_END_GREEN:   cfg_q.end_color[1]   <= cfg_data[CH_BITS-1:0];
				REG_END_BLUE:    cfg_q.end_color[2]   <= cfg_data[CH_BITS-1:0];
				REG_STEP_TOTAL:  cfg_q.total          <= cfg_data[STEP_BITS-1:0];
				default: begin
					// unknown index: drop the write
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/pcg_front.sv =====
// ----------------------------------------------------------------------------
// pcg_front: step classification and scaling
// Folds the step, flags zero total and out-of-range steps, and forms the
// per-channel products that the divider back end works on.
// ----------------------------------------------------------------------------
module pcg_front (
	input  logic          clk,
	input  logic          arst_n,
	pcg_step_if.sink      step,
	input  pcg_pkg::cfg_t cfg,
	output logic          push_valid,
	input  logic          push_ready,
	output pcg_pkg::job_t push_data
);
	import pcg_pkg::*;

	typedef struct packed {
		status_t              status;
		logic [STEP_BITS-1:0] pos;
		logic [N_CH-1:0]      down;
		rgb_t                 mag;
	} fold_t;

	fold_t               fold_d;
	fold_t               fold_s1;
	logic                vld_s1;
	logic [IDX_BITS-1:0] twice;
	logic [IDX_BITS-1:0] back_off;
	logic                above;
	logic                beyond;

	always_comb begin
		twice    = {cfg.total, 1'b0};
		back_off = twice - step.step_index;
		above    = step.step_index > {1'b0, cfg.total};
		beyond   = step.step_index > twice;

		if (cfg.total == '0) begin
			fold_d.status = ST_ZERO_TOTAL;
		end else if (beyond) begin
			fold_d.status = ST_OUT_OF_RANGE;
		end else begin
			fold_d.status = ST_OK;
		end
		fold_d.pos = above ? back_off[STEP_BITS-1:0] : step.step_index[STEP_BITS-1:0];

		for (int c = 0; c < N_CH; c++) begin
			fold_d.down[c] = cfg.end_color[c] < cfg.start_color[c];
			fold_d.mag[c]  = fold_d.down[c] ? (cfg.start_color[c] - cfg.end_color[c])
			                                : (cfg.end_color[c] - cfg.start_color[c]);
		end
	end

	assign step.ready = !vld_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (step.ready) begin
			vld_s1 <= step.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step.ready && step.valid) begin
			fold_s1 <= fold_d;
		end
	end

	assign push_valid = vld_s1;

	always_comb begin
		push_data.status = fold_s1.status;
		for (int c = 0; c < N_CH; c++) begin
			push_data.lane[c].down = fold_s1.down[c];
			push_data.lane[c].rem  = PROD_BITS'(fold_s1.mag[c]) * PROD_BITS'(fold_s1.pos);
			push_data.lane[c].quot = '0;
		end
	end

endmodule

// ===== design/pcg_queue.sv =====
// ----------------------------------------------------------------------------
// pcg_queue: job queue between front and back
// Small register FIFO; lets the front keep accepting while the back stalls.
// ----------------------------------------------------------------------------
module pcg_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  pcg_pkg::job_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output pcg_pkg::job_t pop_data
);
	import pcg_pkg::*;

	job_t                 entry_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QPTR_BITS:0]   fill_q;
	logic                 do_push;
	logic                 do_pop;

	assign push_ready = fill_q != (QPTR_BITS+1)'(QUEUE_DEPTH);
	assign pop_valid  = fill_q != '0;
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + (QPTR_BITS+1)'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - (QPTR_BITS+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== design/pcg_back.sv =====
// ----------------------------------------------------------------------------
// pcg_back: pipelined divider and color output
// Restoring division by the step total, one quotient bit per stage, then
// floor/ceiling adjust, offset from the start color and the output register.
// ----------------------------------------------------------------------------
module pcg_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  pcg_pkg::job_t pop_data,
	input  pcg_pkg::cfg_t cfg,
	pcg_color_if.source   color
);
	import pcg_pkg::*;

	localparam int NDIV = CH_BITS;

	logic [NDIV-1:0] vld_s;
	job_t            dat_s [NDIV];
	logic [NDIV-1:0] stg_in_vld;
	job_t            stg_in [NDIV];
	job_t            stg_nxt [NDIV];
	logic [NDIV:0]   stg_rdy;
	rgb_t            rgb_d;
	rgb_t            rgb_q;
	status_t         status_q;
	logic            out_vld_q;
	job_t            last;

	// one quotient bit: compare against the divisor shifted into place
	function automatic job_t div_step(job_t j, logic [STEP_BITS-1:0] d, int unsigned sh);
		job_t                 r;
		logic [PROD_BITS-1:0] trial;
		logic                 fits;
		r     = j;
		trial = PROD_BITS'(d) << sh;
		for (int c = 0; c < N_CH; c++) begin
			fits = j.lane[c].rem >= trial;
			if (fits) begin
				r.lane[c].rem = j.lane[c].rem - trial;
			end
			r.lane[c].quot = {j.lane[c].quot[CH_BITS-2:0], fits};
		end
		return r;
	endfunction

	always_comb begin
		stg_in_vld[0] = pop_valid;
		stg_in[0]     = pop_data;
		for (int k = 1; k < NDIV; k++) begin
			stg_in_vld[k] = vld_s[k-1];
			stg_in[k]     = dat_s[k-1];
		end
		for (int k = 0; k < NDIV; k++) begin
			stg_nxt[k] = div_step(stg_in[k], cfg.total, (NDIV - 1 - k));
		end
		// a stage advances when it is empty or its successor advances
		stg_rdy[NDIV] = !out_vld_q || color.ready;
		for (int k = NDIV - 1; k >= 0; k--) begin
			stg_rdy[k] = !vld_s[k] || stg_rdy[k+1];
		end
	end

	assign pop_ready = stg_rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < NDIV; k++) begin
				if (stg_rdy[k]) begin
					vld_s[k] <= stg_in_vld[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NDIV; k++) begin
			if (stg_rdy[k] && stg_in_vld[k]) begin
				dat_s[k] <= stg_nxt[k];
			end
		end
	end

	// falling channels take the ceiling so they never pass the end color
	always_comb begin
		last = dat_s[NDIV-1];
		for (int c = 0; c < N_CH; c++) begin
			if (last.status != ST_OK) begin
				rgb_d[c] = cfg.start_color[c];
			end else if (last.lane[c].down) begin
				rgb_d[c] = cfg.start_color[c] - last.lane[c].quot
				           - CH_BITS'(last.lane[c].rem != '0);
			end else begin
				rgb_d[c] = cfg.start_color[c] + last.lane[c].quot;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (stg_rdy[NDIV]) begin
			out_vld_q <= vld_s[NDIV-1];
		end
	end

	always_ff @(posedge clk) begin
		if (stg_rdy[NDIV] && vld_s[NDIV-1]) begin
			rgb_q    <= rgb_d;
			status_q <= last.status;
		end
	end

	assign color.valid  = out_vld_q;
	assign color.red    = rgb_q[0];
	assign color.green  = rgb_q[1];
	assign color.blue   = rgb_q[2];
	assign color.status = status_q;

endmodule

// ===== design/pingpong_color_gradient.sv =====
// ----------------------------------------------------------------------------
// pingpong_color_gradient: ping-pong linear color gradient
// Maps a step number to the RGB color at that point of a forth-and-back
// sweep between two configured colors, with exact floor division.
//
//   channel    dir   transaction carries
//   ---------  ----  ---------------------------------------------
//   step       in    step_index
//   color      out   red, green, blue, status
//   cfg_*      in    register write: cfg_we, cfg_index, cfg_data
//
// One step is taken per cycle unless the queue is full; a result passes through
// one classify/scale stage, one queue slot, eight divider stages (one
// quotient bit each) and the output register. Reset loads the default colors
// and a step total of one and empties all stages at once. A stalled color
// output holds the back end; the queue and front stage keep taking steps
// until they fill.
// ----------------------------------------------------------------------------
module pingpong_color_gradient (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pcg_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [pcg_pkg::CFG_DATA_BITS-1:0] cfg_data,
	pcg_step_if.sink                          step,
	pcg_color_if.source                       color
);
	import pcg_pkg::*;

	cfg_t cfg;
	logic push_valid;
	logic push_ready;
	job_t push_data;
	logic pop_valid;
	logic pop_ready;
	job_t pop_data;

	pcg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pcg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.cfg        (cfg),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	pcg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	pcg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.cfg       (cfg),
		.color     (color)
	);

endmodule

// ===== verif/pingpong_color_gradient_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pingpong_color_gradient_tb: self-checking bench for the ping-pong gradient
// Walks a short table of directed steps (reset colors, zero total, widest
// total, rounding on falling channels), then random sweeps under several
// gradient settings. It compares every color transaction against a table value
// or a local gradient calculator, with random gaps on the step side and random
// back-pressure on the color side.
// ----------------------------------------------------------------------------
module pingpong_color_gradient_tb;
	import pcg_pkg::*;

	localparam int                    CYCLE_LIMIT = 200000;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 3'd7; // index past the register file

	typedef struct packed {
		logic [CH_BITS-1:0] red;
		logic [CH_BITS-1:0] green;
		logic [CH_BITS-1:0] blue;
	} color_t;

	typedef struct packed {
		logic [CH_BITS-1:0] red;
		logic [CH_BITS-1:0] green;
		logic [CH_BITS-1:0] blue;
		status_t            status;
	} shade_t;

	typedef enum logic {ROW_SETUP, ROW_STEP} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		color_t               origin;
		color_t               target;
		logic [STEP_BITS-1:0] total;
		logic [IDX_BITS-1:0]  step;
		logic                 known;
		shade_t               want;
	} plan_row_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	pcg_step_if  step_if ();
	pcg_color_if color_if ();

	pingpong_color_gradient dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (step_if),
		.color     (color_if)
	);

	// local copy of the gradient registers, reset values
	color_t               grad_origin = 24'h000000;
	color_t               grad_target = 24'hFFFFFF;
	logic [STEP_BITS-1:0] grad_total  = 16'd1;

	shade_t      expected_shades[$];
	plan_row_t   plan[$];
	logic        pinned_known = 1'b0;
	shade_t      pinned_shade = '0;
	bit          calm = 1'b0;
	int unsigned sweep_pos;
	int          mismatches = 0;
	int          colors_checked = 0;
	int          steps_taken = 0;
	int          setups = 0;
	int          cycles = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d colors outstanding", cycles,
				expected_shades.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// gradient calculator
	// ------------------------------------------------------------------
	function automatic logic [CH_BITS-1:0] mix_channel(input logic [CH_BITS-1:0] lo,
		input logic [CH_BITS-1:0] hi, input longint unsigned pos,
		input longint unsigned count);
		longint unsigned span;
		if (hi >= lo) begin
			span = (64'(hi) - 64'(lo)) * pos;
			return lo + CH_BITS'(span / count);
		end
		// falling channel: round the drop up so the floor of the value holds
		span = (64'(lo) - 64'(hi)) * pos;
		return lo - CH_BITS'((span + count - 1) / count);
	endfunction

	function automatic shade_t gradient_color(input logic [IDX_BITS-1:0] idx);
		shade_t          s;
		longint unsigned count;
		longint unsigned pos;
		count    = 64'(grad_total);
		s.red    = grad_origin.red;
		s.green  = grad_origin.green;
		s.blue   = grad_origin.blue;
		s.status = ST_OK;
		if (count == 0) begin
			s.status = ST_ZERO_TOTAL;
		end else if (idx > 2 * count) begin
			s.status = ST_OUT_OF_RANGE;
		end else begin
			pos     = (idx > count) ? 2 * count - idx : idx;
			s.red   = mix_channel(grad_origin.red, grad_target.red, pos, count);
			s.green = mix_channel(grad_origin.green, grad_target.green, pos, count);
			s.blue  = mix_channel(grad_origin.blue, grad_target.blue, pos, count);
		end
		return s;
	endfunction

	// ------------------------------------------------------------------
	// monitors
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && cfg_we) begin
			case (cfg_index)
				REG_START_RED:   grad_origin.red   <= cfg_data[CH_BITS-1:0];
				REG_START_GREEN: grad_origin.green <= cfg_data[CH_BITS-1:0];
				REG_START_BLUE:  grad_origin.blue  <= cfg_data[CH_BITS-1:0];
				REG_END_RED:     grad_target.red   <= cfg_data[CH_BITS-1:0];
				REG_END_GREEN:   grad_target.green <= cfg_data[CH_BITS-1:0];
				REG_END_BLUE:    grad_target.blue  <= cfg_data[CH_BITS-1:0];
				REG_STEP_TOTAL:  grad_total        <= cfg_data[STEP_BITS-1:0];
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && step_if.valid && step_if.ready) begin
			expected_shades.push_back(pinned_known ? pinned_shade
				: gradient_color(step_if.step_index));
			steps_taken++;
		end
	end

	task automatic flag_mismatch(input string what, input shade_t want, input shade_t got);
		if (mismatches < 10)
			$display("[%0t] %s: expected r=%0d g=%0d b=%0d st=%0d, got r=%0d g=%0d b=%0d st=%0d",
				$realtime, what, want.red, want.green, want.blue, want.status,
				got.red, got.green, got.blue, got.status);
		mismatches++;
	endtask

	always @(posedge clk) begin
		shade_t got;
		shade_t want;
		if (arst_n && color_if.valid && color_if.ready) begin
			got.red    = color_if.red;
			got.green  = color_if.green;
			got.blue   = color_if.blue;
			got.status = status_t'(color_if.status);
			if (expected_shades.size() == 0) begin
				flag_mismatch("color with no step pending", '0, got);
			end else begin
				want = expected_shades.pop_front();
				colors_checked++;
				if (got.red !== want.red || got.green !== want.green
					|| got.blue !== want.blue || got.status !== want.status)
					flag_mismatch("color mismatch", want, got);
			end
		end
	end

	// back-pressure on the color side
	initial begin
		color_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			color_if.ready <= calm || ($urandom_range(99) >= 7);
		end
	end

	// ------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	// drain, then load a full gradient setting; color writes carry junk above bit 7
	task automatic setup_gradient(input color_t origin, input color_t target,
		input logic [STEP_BITS-1:0] total);
		step_if.valid <= 1'b0;
		@(posedge clk);
		while (expected_shades.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		write_reg(REG_START_RED,   {8'($urandom), origin.red});
		write_reg(REG_START_GREEN, {8'($urandom), origin.green});
		write_reg(REG_START_BLUE,  {8'($urandom), origin.blue});
		write_reg(REG_END_RED,     {8'($urandom), target.red});
		write_reg(REG_END_GREEN,   {8'($urandom), target.green});
		write_reg(REG_END_BLUE,    {8'($urandom), target.blue});
		write_reg(REG_STEP_TOTAL,  total);
		write_reg(REG_SPARE,       16'($urandom));
		cfg_we <= 1'b0;
		setups++;
	endtask

	task automatic send_step(input logic [IDX_BITS-1:0] idx, input logic known,
		input shade_t want);
		while (!calm && $urandom_range(99) < 7) begin
			step_if.valid <= 1'b0;
			@(posedge clk);
		end
		step_if.valid      <= 1'b1;
		step_if.step_index <= idx;
		pinned_known       <= known;
		pinned_shade       <= want;
		do @(posedge clk); while (!step_if.ready);
	endtask

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic shade_t shade(input int r, input int g, input int b,
		input status_t st);
		shade_t s;
		s.red    = CH_BITS'(r);
		s.green  = CH_BITS'(g);
		s.blue   = CH_BITS'(b);
		s.status = st;
		return s;
	endfunction

	function automatic void plan_setup(input color_t origin, input color_t target,
		input logic [STEP_BITS-1:0] total);
		plan_row_t row;
		row        = '0;
		row.kind   = ROW_SETUP;
		row.origin = origin;
		row.target = target;
		row.total  = total;
		plan.push_back(row);
	endfunction

	function automatic void plan_step(input logic [IDX_BITS-1:0] idx, input logic known,
		input shade_t want);
		plan_row_t row;
		row       = '0;
		row.kind  = ROW_STEP;
		row.step  = idx;
		row.known = known;
		row.want  = want;
		plan.push_back(row);
	endfunction

	function automatic logic [CH_BITS-1:0] pick_level();
		case ($urandom_range(3))
			0:       return 8'd0;
			1:       return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	// half the time a running sweep through one forth-and-back period, with jumps,
	// fold points and out-of-range noise mixed in
	function automatic logic [IDX_BITS-1:0] pick_step(input int unsigned total);
		int unsigned idx;
		case ($urandom_range(19))
			0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
				idx       = sweep_pos;
				sweep_pos = (sweep_pos >= 2 * total) ? 0 : sweep_pos + 1;
			end
			10, 11, 12, 13, 14: idx = $urandom_range(2 * total, 0);
			15:      idx = total;
			16:      idx = 2 * total;
			17:      idx = 2 * total + 1;
			default: idx = $urandom;
		endcase
		return IDX_BITS'(idx);
	endfunction

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		color_t               origin;
		color_t               target;
		int unsigned          total;
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = '0;
		cfg_data           = '0;
		step_if.valid      = 1'b0;
		step_if.step_index = '0;

		// reset colors: black to white over one step
		plan_step(17'd0,      1'b1, shade(0,   0,   0,   ST_OK));
		plan_step(17'd1,      1'b1, shade(255, 255, 255, ST_OK));
		plan_step(17'd2,      1'b1, shade(0,   0,   0,   ST_OK));
		plan_step(17'd3,      1'b1, shade(0,   0,   0,   ST_OUT_OF_RANGE));
		plan_step(17'h1FFFF,  1'b1, shade(0,   0,   0,   ST_OUT_OF_RANGE));
		// zero total wins over the range check
		plan_setup({8'd10, 8'd20, 8'd30}, {8'd200, 8'd100, 8'd5}, 16'd0);
		plan_step(17'd0,      1'b1, shade(10, 20, 30, ST_ZERO_TOTAL));
		plan_step(17'h1FFFF,  1'b1, shade(10, 20, 30, ST_ZERO_TOTAL));
		// widest total
		plan_setup({8'd255, 8'd0, 8'd128}, {8'd0, 8'd255, 8'd128}, 16'hFFFF);
		plan_step(17'd65535,  1'b1, shade(0,   255, 128, ST_OK));
		plan_step(17'd131070, 1'b1, shade(255, 0,   128, ST_OK));
		plan_step(17'h1FFFF,  1'b1, shade(255, 0,   128, ST_OUT_OF_RANGE));
		plan_step(17'd1,      1'b0, '0);
		plan_step(17'd32768,  1'b0, '0);
		plan_step(17'd98303,  1'b0, '0);
		// short total, rising and falling channels round down
		plan_setup({8'd0, 8'd255, 8'd7}, {8'd255, 8'd0, 8'd200}, 16'd3);
		for (int i = 0; i <= 6; i++)
			plan_step(IDX_BITS'(i), 1'b0, '0);
		plan_step(17'd7,      1'b1, shade(0, 255, 7, ST_OUT_OF_RANGE));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_SETUP)
				setup_gradient(plan[i].origin, plan[i].target, plan[i].total);
			else
				send_step(plan[i].step, plan[i].known, plan[i].want);
		end

		for (int phase = 0; phase < 10; phase++) begin
			origin = {pick_level(), pick_level(), pick_level()};
			target = {pick_level(), pick_level(), pick_level()};
			case (phase)
				0:       total = 1;
				1:       total = 65535;
				2:       total = 0;
				3:       total = $urandom_range(65534, 40000);
				default: total = $urandom_range(400, 2);
			endcase
			// one phase runs with no gaps on either side
			calm <= (phase == 4);
			setup_gradient(origin, target, STEP_BITS'(total));
			sweep_pos = $urandom_range(2 * total, 0);
			repeat (165) send_step(pick_step(total), 1'b0, '0);
		end
		calm <= 1'b0;

		step_if.valid <= 1'b0;
		@(posedge clk);
		while (expected_shades.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		mismatches += expected_shades.size();

		$display("ran %0d steps across %0d gradient settings, incl. zero and full totals",
			steps_taken, setups);
		$display("checked %0d colors, %0d mismatches", colors_checked, mismatches);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== files.f =====
design/pcg_pkg.sv
design/pcg_step_if.sv
design/pcg_color_if.sv
design/pcg_cfg.sv
design/pcg_front.sv
design/pcg_queue.sv
design/pcg_back.sv
design/pingpong_color_gradient.sv
verif/pingpong_color_gradient_tb.sv
